FILE: src/ufp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufp_pkg
// Shared types, character codes and helpers for the form body parser.
// ----------------------------------------------------------------------------
package ufp_pkg;

    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_AMP   = 8'h26;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_PCT   = 8'h25;

    localparam logic [1:0] PART_NAME  = 2'd0;
    localparam logic [1:0] PART_VALUE = 2'd1;
    localparam logic [1:0] PART_END   = 2'd2;

    localparam logic [1:0] ESC_NONE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HI   = 2'd2;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] part;
        logic       end_of_input;
        logic       last_in_step;
    } t_res;

    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [3:0] d;
        d = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            d = b[3:0] + 4'd9;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: src/ufp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufp_if
// Valid/ready channels for raw body bytes and decoded results.
// ----------------------------------------------------------------------------
interface ufp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ufp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] part;
    logic       end_of_input;
    logic       last_in_step;

    modport source (output valid, output out_byte, output part, output end_of_input,
                    output last_in_step, input ready);
    modport sink   (input valid, input out_byte, input part, input end_of_input,
                    input last_in_step, output ready);
endinterface
`default_nettype wire

FILE: src/ufp_res_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufp_res_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module ufp_res_fifo (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [1:0]          i_push_cnt,
    input  wire  ufp_pkg::t_res i_res0,
    input  wire  ufp_pkg::t_res i_res1,
    output logic                o_space_ok,
    ufp_out_if.source           o_out
);

    ufp_pkg::t_res                     r_mem [ufp_pkg::RES_DEPTH];
    logic [ufp_pkg::RES_PTR_W-1:0]     r_rd;
    logic [ufp_pkg::RES_PTR_W-1:0]     r_wr;
    logic [ufp_pkg::RES_CNT_W-1:0]     r_cnt;
    logic [ufp_pkg::RES_PTR_W-1:0]     n_rd;
    logic [ufp_pkg::RES_PTR_W-1:0]     n_wr;
    logic [ufp_pkg::RES_CNT_W-1:0]     n_cnt;
    logic                              pop;

    assign pop          = o_out.valid && o_out.ready;
    assign o_out.valid  = (r_cnt != '0);
    assign o_out.out_byte     = r_mem[r_rd].out_byte;
    assign o_out.part         = r_mem[r_rd].part;
    assign o_out.end_of_input = r_mem[r_rd].end_of_input;
    assign o_out.last_in_step = r_mem[r_rd].last_in_step;
    // room for two results, whatever leaves this cycle
    assign o_space_ok = (r_cnt <= ufp_pkg::RES_CNT_W'(ufp_pkg::RES_DEPTH - 2));

    always_comb begin
        n_rd  = r_rd + ufp_pkg::RES_PTR_W'(pop);
        n_wr  = r_wr + ufp_pkg::RES_PTR_W'(i_push_cnt);
        n_cnt = r_cnt + ufp_pkg::RES_CNT_W'(i_push_cnt) - ufp_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + ufp_pkg::RES_PTR_W'(1)] <= i_res1;
        end
    end

endmodule
`default_nettype wire

FILE: src/url_encoded_form_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_encoded_form_parser_core
// Splits a URL-encoded form body into name/value bytes and field ends.
// ----------------------------------------------------------------------------
// Output: results of an accepted byte enter the result queue and are offered
// behind older ones. Throughput: one byte per cycle while the queue has room
// for two results; the four-entry queue absorbs bytes giving two results.
// Reset: synchronous, active low; clears parser state and empties the queue.
// ----------------------------------------------------------------------------
module url_encoded_form_parser_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ufp_in_if.sink     i_in,
    ufp_out_if.source  o_out
);

    logic          r_in_value;
    logic [1:0]    r_esc;
    logic [3:0]    r_hi;
    logic          n_in_value;
    logic [1:0]    n_esc;
    logic [3:0]    n_hi;

    ufp_pkg::t_res s0;
    ufp_pkg::t_res s1;
    ufp_pkg::t_res tail;
    logic [1:0]    cnt;
    logic          closed;
    logic          acc;
    logic          space_ok;
    logic [7:0]    b;
    logic [3:0]    hexd;

    assign i_in.ready = space_ok;
    assign acc        = i_in.valid && space_ok;

    always_comb begin
        b          = i_in.in_byte;
        hexd       = ufp_pkg::hex_digit(b);
        n_in_value = r_in_value;
        n_esc      = r_esc;
        n_hi       = r_hi;
        s0         = '0;
        s1         = '0;
        tail       = '0;
        cnt        = 2'd0;
        closed     = 1'b0;

        if (!r_in_value) begin
            if (b == ufp_pkg::CHR_AMP) begin
                s0 = '{8'd0, ufp_pkg::PART_END, 1'b0, 1'b0};
                cnt = 2'd1;
                closed = 1'b1;
            end else if (b == ufp_pkg::CHR_EQ) begin
                n_in_value = 1'b1;
            end else begin
                s0 = '{b, ufp_pkg::PART_NAME, 1'b0, 1'b0};
                cnt = 2'd1;
            end
        end else if (r_esc == ufp_pkg::ESC_NONE) begin
            if (b == ufp_pkg::CHR_PCT) begin
                n_esc = ufp_pkg::ESC_PCT;
                n_hi  = 4'd0;
            end else if (b == ufp_pkg::CHR_PLUS) begin
                s0 = '{ufp_pkg::CHR_SPACE, ufp_pkg::PART_VALUE, 1'b0, 1'b0};
                cnt = 2'd1;
            end else if (b == ufp_pkg::CHR_AMP) begin
                s0 = '{8'd0, ufp_pkg::PART_END, 1'b0, 1'b0};
                cnt = 2'd1;
                closed = 1'b1;
            end else begin
                s0 = '{b, ufp_pkg::PART_VALUE, 1'b0, 1'b0};
                cnt = 2'd1;
            end
        end else if (r_esc == ufp_pkg::ESC_PCT) begin
            if (b == ufp_pkg::CHR_AMP) begin
                s0 = '{8'd0, ufp_pkg::PART_VALUE, 1'b0, 1'b0};
                s1 = '{8'd0, ufp_pkg::PART_END, 1'b0, 1'b0};
                cnt = 2'd2;
                closed = 1'b1;
            end else begin
                n_hi  = hexd;
                n_esc = ufp_pkg::ESC_HI;
            end
        end else begin
            if (b == ufp_pkg::CHR_AMP) begin
                s0 = '{{r_hi, 4'd0}, ufp_pkg::PART_VALUE, 1'b0, 1'b0};
                s1 = '{8'd0, ufp_pkg::PART_END, 1'b0, 1'b0};
                cnt = 2'd2;
                closed = 1'b1;
            end else begin
                s0 = '{{r_hi, hexd}, ufp_pkg::PART_VALUE, 1'b0, 1'b0};
                cnt = 2'd1;
                n_esc = ufp_pkg::ESC_NONE;
                n_hi  = 4'd0;
            end
        end

        if (!closed && i_in.last_byte) begin
            // escape cut short by end of input: missing digits are zero
            if (n_in_value && n_esc != ufp_pkg::ESC_NONE) begin
                tail = '{(n_esc == ufp_pkg::ESC_PCT) ? 8'd0 : {n_hi, 4'd0},
                         ufp_pkg::PART_VALUE, 1'b0, 1'b0};
                if (cnt == 2'd0) begin
                    s0 = tail;
                end else begin
                    s1 = tail;
                end
                cnt = cnt + 2'd1;
            end
            tail = '{8'd0, ufp_pkg::PART_END, 1'b0, 1'b0};
            if (cnt == 2'd0) begin
                s0 = tail;
            end else begin
                s1 = tail;
            end
            cnt = cnt + 2'd1;
        end

        if (closed || i_in.last_byte) begin
            n_in_value = 1'b0;
            n_esc      = ufp_pkg::ESC_NONE;
            n_hi       = 4'd0;
        end

        if (cnt == 2'd1) begin
            s0.last_in_step = 1'b1;
            s0.end_of_input = i_in.last_byte;
        end else if (cnt == 2'd2) begin
            s1.last_in_step = 1'b1;
            s1.end_of_input = i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_value <= 1'b0;
            r_esc      <= ufp_pkg::ESC_NONE;
            r_hi       <= 4'd0;
        end else if (acc) begin
            r_in_value <= n_in_value;
            r_esc      <= n_esc;
            r_hi       <= n_hi;
        end
    end

    ufp_res_fifo u_res_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (acc ? cnt : 2'd0),
        .i_res0     (s0),
        .i_res1     (s1),
        .o_space_ok (space_ok),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

FILE: tb/sv/url_encoded_form_parser_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_encoded_form_parser_core_tb
// Self-checking bench for the form body parser. A short table of directed
// bytes (extremes, escapes, cut escapes, final '&' and '=') is followed by
// randomly built form bodies and raw noise. Every accepted byte is run
// through a local decoder model; each result transaction is compared field
// by field against the oldest expected result. Both channels idle at random.
// ----------------------------------------------------------------------------
module url_encoded_form_parser_core_tb;

    localparam int N_ITEMS   = 1750;
    localparam int CYC_LIMIT = 300000;
    localparam int TAIL_CYC  = 20;

    typedef struct {
        logic [7:0]    b;
        logic          l;
        int            n;      // -1: take the decoder model's results
        ufp_pkg::t_res e0;
        ufp_pkg::t_res e1;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic res_rdy = 1'b0;

    ufp_in_if  in_ch ();
    ufp_out_if out_ch ();

    assign out_ch.ready = res_rdy;

    url_encoded_form_parser_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // decoder model state
    logic       val_part = 1'b0;
    logic [1:0] esc_st   = ufp_pkg::ESC_NONE;
    logic [3:0] hi_dig   = 4'h0;

    ufp_pkg::t_res exp_q [$];
    t_dir_row      dir_q [$];
    int            err_cnt    = 0;
    int            item_cnt   = 0;
    int            cyc_cnt    = 0;
    int            stall_left = 0;
    logic          in_burst   = 1'b0;
    logic          out_burst  = 1'b0;
    ufp_pkg::t_res want;
    ufp_pkg::t_res got;
    int            form_idx;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h37);
        return 4'h0;
    endfunction

    // Advances the model by one body byte; returns the number of results.
    function automatic int decode_form_byte(input logic [7:0] b, input logic l,
                                            output ufp_pkg::t_res r0,
                                            output ufp_pkg::t_res r1);
        ufp_pkg::t_res res [0:1];
        int   n;
        logic closed;
        n      = 0;
        closed = 1'b0;
        res[0] = '0;
        res[1] = '0;
        if (!val_part) begin
            if (b == ufp_pkg::CHR_AMP) begin
                res[n] = {8'h00, ufp_pkg::PART_END, 2'b00};
                n++;
                closed = 1'b1;
            end else if (b == ufp_pkg::CHR_EQ) begin
                val_part = 1'b1;
            end else begin
                res[n] = {b, ufp_pkg::PART_NAME, 2'b00};
                n++;
            end
        end else if (esc_st == ufp_pkg::ESC_NONE) begin
            if (b == ufp_pkg::CHR_PCT) begin
                esc_st = ufp_pkg::ESC_PCT;
                hi_dig = 4'h0;
            end else if (b == ufp_pkg::CHR_AMP) begin
                res[n] = {8'h00, ufp_pkg::PART_END, 2'b00};
                n++;
                closed = 1'b1;
            end else begin
                res[n] = {(b == ufp_pkg::CHR_PLUS) ? ufp_pkg::CHR_SPACE : b,
                          ufp_pkg::PART_VALUE, 2'b00};
                n++;
            end
        end else if (esc_st == ufp_pkg::ESC_PCT) begin
            if (b == ufp_pkg::CHR_AMP) begin
                res[0] = {8'h00, ufp_pkg::PART_VALUE, 2'b00};
                res[1] = {8'h00, ufp_pkg::PART_END, 2'b00};
                n = 2;
                closed = 1'b1;
            end else begin
                hi_dig = hex_val(b);
                esc_st = ufp_pkg::ESC_HI;
            end
        end else begin
            if (b == ufp_pkg::CHR_AMP) begin
                res[0] = {hi_dig, 4'h0, ufp_pkg::PART_VALUE, 2'b00};
                res[1] = {8'h00, ufp_pkg::PART_END, 2'b00};
                n = 2;
                closed = 1'b1;
            end else begin
                res[n] = {hi_dig, hex_val(b), ufp_pkg::PART_VALUE, 2'b00};
                n++;
                esc_st = ufp_pkg::ESC_NONE;
                hi_dig = 4'h0;
            end
        end
        if (!closed && l) begin
            if (val_part && esc_st != ufp_pkg::ESC_NONE) begin
                res[n] = {(esc_st == ufp_pkg::ESC_PCT) ? 8'h00 : {hi_dig, 4'h0},
                          ufp_pkg::PART_VALUE, 2'b00};
                n++;
            end
            res[n] = {8'h00, ufp_pkg::PART_END, 2'b00};
            n++;
        end
        if (closed || l) begin
            val_part = 1'b0;
            esc_st   = ufp_pkg::ESC_NONE;
            hi_dig   = 4'h0;
        end
        if (l && n > 0) res[n-1].end_of_input = 1'b1;
        if (n > 0) res[n-1].last_in_step = 1'b1;
        r0 = res[0];
        r1 = res[1];
        return n;
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(8'h21, 8'h7E));
        end while (c == ufp_pkg::CHR_AMP || c == ufp_pkg::CHR_EQ ||
                   c == ufp_pkg::CHR_PCT || c == ufp_pkg::CHR_PLUS);
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'(8'h30 + v);
        if (v < 16) return 8'(8'h61 + v - 10);
        return 8'(8'h41 + v - 16);
    endfunction

    task automatic add_row(input logic [7:0] b, input logic l, input int n = -1,
                           input ufp_pkg::t_res e0 = '0, input ufp_pkg::t_res e1 = '0);
        t_dir_row row;
        row.b  = b;
        row.l  = l;
        row.n  = n;
        row.e0 = e0;
        row.e1 = e1;
        dir_q.push_back(row);
    endtask

    // One input transaction; a zero gap keeps valid high across items.
    task automatic send_byte(input logic [7:0] b, input logic l, input int n_typed = -1,
                             input ufp_pkg::t_res e0 = '0,
                             input ufp_pkg::t_res e1 = '0);
        int            gap;
        int            n;
        ufp_pkg::t_res r0;
        ufp_pkg::t_res r1;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        gap = in_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= l;
        do @(posedge i_clk); while (!in_ch.ready);
        n = decode_form_byte(b, l, r0, r1);
        if (n_typed >= 0) begin
            n  = n_typed;
            r0 = e0;
            r1 = e1;
        end
        if (n > 0) exp_q.push_back(r0);
        if (n > 1) exp_q.push_back(r1);
        item_cnt++;
    endtask

    task automatic send_form();
        logic [7:0] body [$];
        int nf;
        int k;
        int j;
        int tok;
        nf = $urandom_range(1, 4);
        for (k = 0; k < nf; k++) begin
            if (k > 0) body.push_back(ufp_pkg::CHR_AMP);
            repeat ($urandom_range(0, 5)) begin
                body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                           : plain_char());
            end
            if ($urandom_range(0, 7) != 0) begin
                body.push_back(ufp_pkg::CHR_EQ);
                repeat ($urandom_range(0, 6)) begin
                    tok = $urandom_range(0, 9);
                    case (tok)
                        4: body.push_back(ufp_pkg::CHR_PLUS);
                        5: body.push_back(ufp_pkg::CHR_EQ);
                        6, 7: begin
                            body.push_back(ufp_pkg::CHR_PCT);
                            body.push_back(hex_char());
                            body.push_back(hex_char());
                        end
                        8: begin
                            body.push_back(ufp_pkg::CHR_PCT);
                            body.push_back(plain_char());
                            body.push_back(plain_char());
                        end
                        9: body.push_back(8'($urandom_range(0, 255)));
                        default: body.push_back(plain_char());
                    endcase
                end
                // escape cut short by the separator or the end of input
                if ($urandom_range(0, 5) == 0) begin
                    body.push_back(ufp_pkg::CHR_PCT);
                    if ($urandom_range(0, 1) == 1) body.push_back(hex_char());
                end
            end
        end
        if ($urandom_range(0, 7) == 0) body.push_back(ufp_pkg::CHR_AMP);
        if (body.size() == 0) body.push_back(plain_char());
        for (j = 0; j < body.size(); j++) begin
            send_byte(body[j], (j == body.size() - 1) && ($urandom_range(0, 9) != 0));
        end
    endtask

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.in_byte   <= 8'h00;
        in_ch.last_byte <= 1'b0;

        add_row(8'h00, 1'b0, 1, {8'h00, ufp_pkg::PART_NAME, 1'b0, 1'b1});
        add_row(8'hFF, 1'b0, 1, {8'hFF, ufp_pkg::PART_NAME, 1'b0, 1'b1});
        add_row(ufp_pkg::CHR_EQ, 1'b0, 0);
        add_row(ufp_pkg::CHR_EQ, 1'b0);
        add_row(ufp_pkg::CHR_PLUS, 1'b0);
        add_row(ufp_pkg::CHR_PCT, 1'b0);
        add_row("a", 1'b0);
        add_row("F", 1'b0);
        add_row(ufp_pkg::CHR_PCT, 1'b0);
        add_row("g", 1'b0);
        add_row("0", 1'b0);
        add_row(ufp_pkg::CHR_PCT, 1'b0);
        add_row(ufp_pkg::CHR_AMP, 1'b0, 2, {8'h00, ufp_pkg::PART_VALUE, 1'b0, 1'b0},
                {8'h00, ufp_pkg::PART_END, 1'b0, 1'b1});
        add_row("x", 1'b0);
        add_row(ufp_pkg::CHR_EQ, 1'b0);
        add_row(ufp_pkg::CHR_PCT, 1'b0);
        add_row("7", 1'b0);
        add_row(ufp_pkg::CHR_AMP, 1'b1, 2, {8'h70, ufp_pkg::PART_VALUE, 1'b0, 1'b0},
                {8'h00, ufp_pkg::PART_END, 1'b1, 1'b1});
        add_row("k", 1'b0);
        add_row(ufp_pkg::CHR_EQ, 1'b1, 1, {8'h00, ufp_pkg::PART_END, 1'b1, 1'b1});
        add_row("q", 1'b0);
        add_row(ufp_pkg::CHR_EQ, 1'b0);
        add_row(ufp_pkg::CHR_PCT, 1'b0);
        add_row("C", 1'b1);
        add_row(ufp_pkg::CHR_AMP, 1'b1, 1, {8'h00, ufp_pkg::PART_END, 1'b1, 1'b1});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_q[i]) begin
            send_byte(dir_q[i].b, dir_q[i].l, dir_q[i].n, dir_q[i].e0, dir_q[i].e1);
        end

        form_idx = 0;
        while (item_cnt < N_ITEMS) begin
            if (form_idx % 25 == 5) begin
                // hold off until the result side has drained
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (exp_q.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 12)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end else begin
                send_form();
            end
            form_idx++;
        end

        in_ch.valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("url_encoded_form_parser_core_tb: done, clean");
        end else begin
            $display("url_encoded_form_parser_core_tb: done, errors");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_rdy <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_ch.valid && res_rdy) begin
                got = {out_ch.out_byte, out_ch.part, out_ch.end_of_input, out_ch.last_in_step};
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, got %03h", $time, got);
                    err_cnt++;
                end else begin
                    want = exp_q.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.out_byte, got.out_byte);
                        err_cnt++;
                    end
                    if (got.part !== want.part) begin
                        $display("%0t: part expected %0d got %0d", $time, want.part, got.part);
                        err_cnt++;
                    end
                    if (got.end_of_input !== want.end_of_input) begin
                        $display("%0t: end_of_input expected %b got %b",
                                 $time, want.end_of_input, got.end_of_input);
                        err_cnt++;
                    end
                    if (got.last_in_step !== want.last_in_step) begin
                        $display("%0t: last_in_step expected %b got %b",
                                 $time, want.last_in_step, got.last_in_step);
                        err_cnt++;
                    end
                end
                if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
                stall_left = out_burst ? 0 : $urandom_range(0, 6);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            res_rdy <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYC_LIMIT) begin
            $display("url_encoded_form_parser_core_tb: done, errors");
            $finish;
        end
    end

endmodule
